>>> rtl/core/aabb_pct_pkg.sv
package aabb_pct_pkg;

  // default table depth, legal range 2 to 32
  localparam int MAX_BOXES_DEF = 16;

  // field widths fixed by the interface
  localparam int OP_W    = 3;
  localparam int ID_IN_W = 8;
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 8;
  localparam int MASK_W  = 16;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_SET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_TEST   = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  // one stored box
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
  } box_t;

  // sweep sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SWEEP,
    SEQ_FLUSH,
    SEQ_POST
  } seq_state_t;

  // status from sequencer to datapath
  typedef struct packed {
    logic issue;  // a pair read is launched this cycle
    logic post;   // sweep finished, result is loaded into the output register
    logic busy;   // sequencer not idle
  } seq_stat_t;

endpackage

>>> rtl/core/aabb_pct_box_mem.sv
module aabb_pct_box_mem #(
  parameter int MAX_BOXES = aabb_pct_pkg::MAX_BOXES_DEF,
  parameter int ID_W      = $clog2(MAX_BOXES)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ID_W-1:0]     wr_addr,
  input  aabb_pct_pkg::box_t  wr_data,
  input  logic [ID_W-1:0]     rd_addr_a,
  input  logic [ID_W-1:0]     rd_addr_b,
  output aabb_pct_pkg::box_t  rd_data_a,
  output aabb_pct_pkg::box_t  rd_data_b
);

  aabb_pct_pkg::box_t mem [MAX_BOXES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> rtl/core/aabb_pct_overlap.sv
module aabb_pct_overlap (
  input  aabb_pct_pkg::box_t a,
  input  aabb_pct_pkg::box_t b,
  output logic               hit
);

  localparam int EXT_W = aabb_pct_pkg::POS_W + 1;

  logic signed [EXT_W-1:0] ax, ay, bx, by;
  logic signed [EXT_W-1:0] ax_end, ay_end, bx_end, by_end;

  // 17 bit sums, no wrap
  always_comb begin
    ax = EXT_W'(a.x);
    ay = EXT_W'(a.y);
    bx = EXT_W'(b.x);
    by = EXT_W'(b.y);
    ax_end = ax + $signed({1'b0, (EXT_W-1)'(a.w)});
    ay_end = ay + $signed({1'b0, (EXT_W-1)'(a.h)});
    bx_end = bx + $signed({1'b0, (EXT_W-1)'(b.w)});
    by_end = by + $signed({1'b0, (EXT_W-1)'(b.h)});
    hit = (ax < bx_end) && (bx < ax_end) && (ay < by_end) && (by < ay_end);
  end

endmodule

>>> rtl/core/aabb_pct_seq.sv
module aabb_pct_seq #(
  parameter int MAX_BOXES = aabb_pct_pkg::MAX_BOXES_DEF,
  parameter int ID_W      = $clog2(MAX_BOXES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    out_free,
  output logic [ID_W-1:0]         idx_i,
  output logic [ID_W-1:0]         idx_j,
  output aabb_pct_pkg::seq_stat_t stat
);

  localparam logic [ID_W-1:0] LAST_J = ID_W'(MAX_BOXES - 1);
  localparam logic [ID_W-1:0] LAST_I = ID_W'(MAX_BOXES - 2);

  aabb_pct_pkg::seq_state_t state, state_next;
  logic [ID_W-1:0] idx_i_next, idx_j_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aabb_pct_pkg::SEQ_IDLE;
      idx_i <= '0;
      idx_j <= '0;
    end else begin
      state <= state_next;
      idx_i <= idx_i_next;
      idx_j <= idx_j_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_i_next = idx_i;
    idx_j_next = idx_j;
    stat       = '0;
    case (state)
      aabb_pct_pkg::SEQ_IDLE: begin
        if (start) begin
          state_next = aabb_pct_pkg::SEQ_SWEEP;
          idx_i_next = '0;
          idx_j_next = ID_W'(1);
        end
      end
      aabb_pct_pkg::SEQ_SWEEP: begin
        stat.issue = 1'b1;
        stat.busy  = 1'b1;
        if (idx_j == LAST_J) begin
          if (idx_i == LAST_I) begin
            state_next = aabb_pct_pkg::SEQ_FLUSH;
          end else begin
            idx_i_next = idx_i + ID_W'(1);
            idx_j_next = idx_i + ID_W'(2);
          end
        end else begin
          idx_j_next = idx_j + ID_W'(1);
        end
      end
      aabb_pct_pkg::SEQ_FLUSH: begin
        // last pair is compared in this cycle
        stat.busy  = 1'b1;
        state_next = aabb_pct_pkg::SEQ_POST;
      end
      aabb_pct_pkg::SEQ_POST: begin
        stat.busy = 1'b1;
        stat.post = out_free;
        if (out_free) begin
          state_next = aabb_pct_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = aabb_pct_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/aabb_pairwise_collision_table.sv
// channel   dir  width  contents
// s_axis    in   72     opcode, box_id, other_id, pos_x, pos_y, width, height
// m_axis    out  24     collide_mask, pair_hit, done_res
//
// clear, set, remove, query and unused codes: result in the next cycle
// test all: all MAX_BOXES*(MAX_BOXES-1)/2 pairs go through the shared compare unit,
// then flush, post (waits for a free output register) and back to idle
// the pair walk is set by the two-port box memory, one pair read per cycle
// rst is synchronous; it clears the active mask, all collision masks and the output valid
// an input transfer waits while a test runs (sweep, flush, post) or the output holds an untaken result
module aabb_pairwise_collision_table #(
  parameter int MAX_BOXES = aabb_pct_pkg::MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[2:0], box_id[10:3], other_id[18:11], pos_x[34:19], pos_y[50:35],
  // width[58:51], height[66:59], zero pad [71:67]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // collide_mask[15:0], pair_hit[16], done_res[17], zero pad [23:18]
  output logic [23:0] m_tdata
);

  localparam int ID_W   = $clog2(MAX_BOXES);
  localparam int MASK_W = aabb_pct_pkg::MASK_W;

  // input field unpacking
  logic [aabb_pct_pkg::OP_W-1:0]    opcode;
  logic [aabb_pct_pkg::ID_IN_W-1:0] box_id, other_id;
  aabb_pct_pkg::box_t               in_box;

  assign opcode   = s_tdata[2:0];
  assign box_id   = s_tdata[10:3];
  assign other_id = s_tdata[18:11];
  assign in_box.x = s_tdata[34:19];
  assign in_box.y = s_tdata[50:35];
  assign in_box.w = s_tdata[58:51];
  assign in_box.h = s_tdata[66:59];

  logic in_xfer;
  logic id_ok, other_ok;
  logic [ID_W-1:0] id_idx, other_idx;

  assign in_xfer   = s_tvalid && s_tready;
  assign id_ok     = 32'(box_id) < 32'(MAX_BOXES);
  assign other_ok  = 32'(other_id) < 32'(MAX_BOXES);
  assign id_idx    = box_id[ID_W-1:0];
  assign other_idx = other_id[ID_W-1:0];

  // sequencer for the pair sweep
  aabb_pct_pkg::seq_stat_t seq_stat;
  logic [ID_W-1:0] pair_i, pair_j;
  logic out_free, start_test;

  assign out_free   = !m_tvalid || m_tready;
  assign start_test = in_xfer && (aabb_pct_pkg::op_t'(opcode) == aabb_pct_pkg::OP_TEST);
  assign s_tready   = !seq_stat.busy && out_free;

  aabb_pct_seq #(
    .MAX_BOXES (MAX_BOXES),
    .ID_W      (ID_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start_test),
    .out_free (out_free),
    .idx_i    (pair_i),
    .idx_j    (pair_j),
    .stat     (seq_stat)
  );

  // box store, written by set, read two boxes at a time by the sweep
  aabb_pct_pkg::box_t box_a, box_b;
  logic box_wr;

  assign box_wr = in_xfer && id_ok &&
                  (aabb_pct_pkg::op_t'(opcode) == aabb_pct_pkg::OP_SET);

  aabb_pct_box_mem #(
    .MAX_BOXES (MAX_BOXES),
    .ID_W      (ID_W)
  ) u_box_mem (
    .clk       (clk),
    .wr_en     (box_wr),
    .wr_addr   (id_idx),
    .wr_data   (in_box),
    .rd_addr_a (pair_i),
    .rd_addr_b (pair_j),
    .rd_data_a (box_a),
    .rd_data_b (box_b)
  );

  // shared compare unit sees the pair read in the previous cycle
  logic overlap;
  logic cmp_valid;
  logic [ID_W-1:0] cmp_i, cmp_j;

  aabb_pct_overlap u_overlap (
    .a   (box_a),
    .b   (box_b),
    .hit (overlap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= seq_stat.issue;
    end
  end

  always_ff @(posedge clk) begin
    cmp_i <= pair_i;
    cmp_j <= pair_j;
  end

  // active mask and collision masks
  logic [MAX_BOXES-1:0] active;
  logic [MAX_BOXES-1:0] hit_masks [MAX_BOXES];
  logic pair_set;

  // active bits are stable for the whole sweep
  assign pair_set = cmp_valid && overlap && active[cmp_i] && active[cmp_j];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int k = 0; k < MAX_BOXES; k++) begin
        hit_masks[k] <= '0;
      end
    end else if (in_xfer) begin
      case (aabb_pct_pkg::op_t'(opcode))
        aabb_pct_pkg::OP_CLEAR: begin
          active <= '0;
          for (int k = 0; k < MAX_BOXES; k++) begin
            hit_masks[k] <= '0;
          end
        end
        aabb_pct_pkg::OP_SET: begin
          if (id_ok) begin
            active[id_idx] <= 1'b1;
          end
        end
        aabb_pct_pkg::OP_REMOVE: begin
          // other boxes keep their bit for this one until the next sweep or clear
          if (id_ok) begin
            active[id_idx]    <= 1'b0;
            hit_masks[id_idx] <= '0;
          end
        end
        aabb_pct_pkg::OP_TEST: begin
          for (int k = 0; k < MAX_BOXES; k++) begin
            hit_masks[k] <= '0;
          end
        end
        default: begin
        end
      endcase
    end else if (pair_set) begin
      hit_masks[cmp_i][cmp_j] <= 1'b1;
      hit_masks[cmp_j][cmp_i] <= 1'b1;
    end
  end

  // query read of one mask row
  logic [MAX_BOXES-1:0] q_row;
  logic [MASK_W-1:0]    q_mask;
  logic                 q_hit;

  always_comb begin
    q_row  = hit_masks[id_idx];
    q_mask = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (k < MAX_BOXES) begin
        q_mask[k] = q_row[k];
      end
    end
    q_hit = q_row[other_idx];
    if (!id_ok) begin
      q_mask = '0;
      q_hit  = 1'b0;
    end else if (!other_ok) begin
      q_hit  = 1'b0;
    end
  end

  // output register
  logic [MASK_W-1:0] out_mask;
  logic              out_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((in_xfer && !start_test) || seq_stat.post) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !start_test) begin
      if (aabb_pct_pkg::op_t'(opcode) == aabb_pct_pkg::OP_QUERY) begin
        out_mask <= q_mask;
        out_hit  <= q_hit;
      end else begin
        out_mask <= '0;
        out_hit  <= 1'b0;
      end
    end else if (seq_stat.post) begin
      out_mask <= '0;
      out_hit  <= 1'b0;
    end
  end

  // done_res is always one
  assign m_tdata = {6'd0, 1'b1, out_hit, out_mask};

endmodule

>>> bench/aabb_pairwise_collision_table_tb.sv
`timescale 1ns / 100ps

module aabb_pairwise_collision_table_tb;
  import aabb_pct_pkg::*;

  localparam int NBOX       = MAX_BOXES_DEF;
  localparam int RAND_ITEMS = 500;
  localparam int STUCK_MAX  = 4000;   // cycles with no transfer on either side
  localparam int DRAIN_CYC  = 8;      // wait after the final drain before the verdict
  localparam int REPORT_MAX = 10;

  // opcodes the block leaves unused
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  // one input transfer, fields as they sit in s_tdata
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_IN_W-1:0] id;
    logic [ID_IN_W-1:0] other;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } table_op_t;

  // one output transfer
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              hit;
    logic              done;
  } reply_t;

  // directed row: typed=1 means the reply is plainly done with no mask or hit
  typedef struct packed {
    table_op_t cmd;
    logic      typed;
  } dir_row_t;

  localparam reply_t DONE_ONLY = '{mask: '0, hit: 1'b0, done: 1'b1};

  // box coordinates widened so the edge sums never wrap
  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } rect_t;

  localparam int DIR_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // query straight out of reset: nothing set yet
    '{'{OP_QUERY,  8'd0,   8'd1,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1},
    // most negative corner, largest box
    '{'{OP_SET,    8'd0,   8'd0,   16'h8000,    16'h8000,    8'd255, 8'd255}, 1'b1},
    '{'{OP_SET,    8'd1,   8'd0,   -16'sd32600, -16'sd32600, 8'd10,  8'd10},  1'b1},
    // most positive corner, edge sums need the 17th bit
    '{'{OP_SET,    8'd2,   8'd0,   16'sd32767,  16'sd32767,  8'd255, 8'd255}, 1'b1},
    '{'{OP_SET,    8'd3,   8'd0,   16'sd32700,  16'sd32700,  8'd100, 8'd100}, 1'b1},
    // zero width box sitting inside box 5
    '{'{OP_SET,    8'd4,   8'd0,   16'sd0,      16'sd0,      8'd0,   8'd50},  1'b1},
    '{'{OP_SET,    8'd5,   8'd0,   16'sd0,      16'sd0,      8'd50,  8'd50},  1'b1},
    // touches box 5 on its right edge only, half-open so no hit
    '{'{OP_SET,    8'd6,   8'd0,   16'sd50,     16'sd0,      8'd10,  8'd10},  1'b1},
    '{'{OP_SET,    8'd15,  8'd0,   -16'sd5,     -16'sd5,     8'd10,  8'd10},  1'b1},
    // out of range id, dropped
    '{'{OP_SET,    8'd255, 8'd255, 16'sd0,      16'sd0,      8'd255, 8'd255}, 1'b1},
    '{'{OP_TEST,   8'd0,   8'd0,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1},
    '{'{OP_QUERY,  8'd0,   8'd1,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    '{'{OP_QUERY,  8'd2,   8'd3,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    '{'{OP_QUERY,  8'd5,   8'd15,  16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    '{'{OP_QUERY,  8'd4,   8'd5,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    '{'{OP_QUERY,  8'd6,   8'd5,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    // second id out of range: mask still comes back, hit bit zero
    '{'{OP_QUERY,  8'd15,  8'd255, 16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    '{'{OP_QUERY,  8'd255, 8'd0,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1},
    // remove clears only its own mask, box 15 keeps the stale bit
    '{'{OP_REMOVE, 8'd5,   8'd0,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1},
    '{'{OP_QUERY,  8'd15,  8'd5,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    '{'{OP_REMOVE, 8'd200, 8'd0,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1},
    '{'{OP_RSVD_LO, 8'd15, 8'd5,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1},
    '{'{OP_RSVD_HI, 8'd15, 8'd5,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1},
    // overwrite an active box, masks stay as they were
    '{'{OP_SET,    8'd1,   8'd0,   16'h8000,    16'h8000,    8'd1,   8'd1},   1'b1},
    '{'{OP_QUERY,  8'd0,   8'd1,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b0},
    '{'{OP_CLEAR,  8'd0,   8'd0,   16'sd0,      16'sd0,      8'd0,   8'd0},   1'b1}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // opcode, box_id, other_id, pos_x, pos_y, width, height, zero pad
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // collide_mask, pair_hit, done_res, zero pad
  logic [23:0] m_tdata;

  // shadow copy of the box table
  rect_t       shadow_rect [NBOX];
  logic [31:0] shadow_hits [NBOX];
  logic [31:0] shadow_active;

  reply_t awaited_replies [$];
  int     bad_replies = 0;
  int     src_gap_pct = 0;
  int     sink_stall_pct = 0;

  aabb_pairwise_collision_table #(
    .MAX_BOXES(NBOX)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // applies one operation to the shadow table and returns the reply it owes
  function automatic reply_t apply_table_op(table_op_t c);
    reply_t r;
    r = DONE_ONLY;
    case (c.op)
      OP_CLEAR: begin
        shadow_active = '0;
        for (int i = 0; i < NBOX; i++) shadow_hits[i] = '0;
      end
      OP_SET: begin
        if (c.id < NBOX) begin
          shadow_rect[c.id].x = int'($signed(c.px));
          shadow_rect[c.id].y = int'($signed(c.py));
          shadow_rect[c.id].w = int'(c.w);
          shadow_rect[c.id].h = int'(c.h);
          shadow_active[c.id] = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (c.id < NBOX) begin
          shadow_active[c.id] = 1'b0;
          shadow_hits[c.id] = '0;
        end
      end
      OP_TEST: begin
        for (int i = 0; i < NBOX; i++) shadow_hits[i] = '0;
        // every active pair once, half-open overlap on both axes
        for (int i = 0; i < NBOX; i++) begin
          for (int j = i + 1; j < NBOX; j++) begin
            if (shadow_active[i] && shadow_active[j] &&
                shadow_rect[i].x < shadow_rect[j].x + shadow_rect[j].w &&
                shadow_rect[j].x < shadow_rect[i].x + shadow_rect[i].w &&
                shadow_rect[i].y < shadow_rect[j].y + shadow_rect[j].h &&
                shadow_rect[j].y < shadow_rect[i].y + shadow_rect[i].h) begin
              shadow_hits[i][j] = 1'b1;
              shadow_hits[j][i] = 1'b1;
            end
          end
        end
      end
      OP_QUERY: begin
        if (c.id < NBOX) begin
          r.mask = shadow_hits[c.id][MASK_W-1:0];
          if (c.other < NBOX) r.hit = shadow_hits[c.id][c.other];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offers one operation, waits for the transfer, then books its reply
  task automatic send_op(input table_op_t c, input logic typed);
    reply_t r;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, c.h, c.w, c.py, c.px, c.other, c.id, c.op};
    do @(posedge clk); while (!s_tready);
    r = apply_table_op(c);
    awaited_replies.push_back(typed ? DONE_ONLY : r);
  endtask

  // holds the input off until every booked reply has come back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // receiver side: random backpressure and reply checking
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          bad_replies++;
          if (bad_replies <= REPORT_MAX)
            $display("%0t: reply with none pending, data %h", $realtime, m_tdata);
        end else begin
          want = awaited_replies.pop_front();
          if (m_tdata[15:0] !== want.mask || m_tdata[16] !== want.hit ||
              m_tdata[17] !== want.done) begin
            bad_replies++;
            if (bad_replies <= REPORT_MAX)
              $display("%0t: reply mismatch mask %h/%h hit %b/%b done %b/%b (exp/act)",
                       $realtime, want.mask, m_tdata[15:0], want.hit, m_tdata[16],
                       want.done, m_tdata[17]);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // watchdog on cycles with no transfer at all
  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_MAX) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("aabb_pairwise_collision_table_tb failed");
    $finish;
  end

  initial begin : stimulus
    table_op_t c;
    int        pick;
    shadow_active = '0;
    for (int i = 0; i < NBOX; i++) begin
      shadow_hits[i] = '0;
      shadow_rect[i] = '{x: 0, y: 0, w: 0, h: 0};
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part: sender mostly busy, receiver mostly stalling
    src_gap_pct = 7;
    sink_stall_pct = 71;
    for (int n = 0; n < DIR_N; n++) send_op(DIR_ROWS[n].cmd, DIR_ROWS[n].typed);
    drain_replies();

    // random part in three phases with different source gap and sink stall rates
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_gap_pct = 7;  sink_stall_pct = 71; end
        1: begin src_gap_pct = 71; sink_stall_pct = 7;  end
        default: begin src_gap_pct = 0; sink_stall_pct = 0; end
      endcase
      for (int n = 0; n < RAND_ITEMS / 3; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)       c.op = OP_CLEAR;
        else if (pick < 43) c.op = OP_SET;
        else if (pick < 53) c.op = OP_REMOVE;
        else if (pick < 63) c.op = OP_TEST;
        else if (pick < 93) c.op = OP_QUERY;
        else                c.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        // mostly valid ids, some out of range
        c.id    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NBOX, 255))
                                              : 8'($urandom_range(0, NBOX - 1));
        c.other = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NBOX, 255))
                                              : 8'($urandom_range(0, NBOX - 1));
        // boxes clustered near the origin so pairs overlap often
        if ($urandom_range(0, 7) == 0) begin
          c.px = 16'($urandom_range(0, 65535));
          c.py = 16'($urandom_range(0, 65535));
        end else begin
          c.px = 16'(int'($urandom_range(0, 600)) - 300);
          c.py = 16'(int'($urandom_range(0, 600)) - 300);
        end
        c.w = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        c.h = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        send_op(c, 1'b0);
      end
      drain_replies();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (bad_replies == 0) begin
      $display("aabb_pairwise_collision_table_tb passed");
    end else begin
      $display("aabb_pairwise_collision_table_tb failed");
    end
    $finish;
  end

endmodule
